@@ design/qpe_pkg.sv @@
package qpe_pkg;

	localparam int MAX_LINE_DEF    = 76;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int COL_W           = 7;
	localparam int CFG_INDEX_W     = 4;
	localparam int CFG_DATA_W      = 64;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_FORCE_MASK_0 = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FORCE_MASK_1 = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FORCE_MASK_2 = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FORCE_MASK_3 = 4'd3;

	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_SP  = 8'd32;
	localparam logic [7:0] CH_EQ  = 8'd61;

	// Characters caused by one encoded byte: an optional soft break and its token, or CR LF for a line feed.
	typedef struct packed {
		logic [5:0][7:0] chars;
		logic [2:0]      len;
	} enc_t;

	typedef struct packed {
		enc_t             enc;
		logic [COL_W-1:0] col;
	} enc_res_t;

	// All characters caused by one input item, in the order they leave.
	typedef struct packed {
		enc_t [1:0] e;
	} job_t;

	function automatic logic [7:0] qpe_hex(input logic [3:0] n);
		logic [7:0] w;
		w = {4'b0000, n};
		return (n < 4'd10) ? (8'd48 + w) : (8'd55 + w);
	endfunction

	function automatic enc_res_t qpe_encode(input logic [7:0] b, input logic [7:0] nx,
			input logic frc, input logic [COL_W-1:0] col, input logic [COL_W-1:0] sb_col);
		enc_res_t        r;
		logic [2:0][7:0] tok;
		logic [2:0]      tl;
		logic            is_crlf;
		r       = '0;
		tok[0]  = CH_EQ;
		tok[1]  = qpe_hex(b[7:4]);
		tok[2]  = qpe_hex(b[3:0]);
		tl      = 3'd3;
		is_crlf = 1'b0;
		if (!frc) begin
			if (b inside {[8'd33:8'd60], [8'd62:8'd126]}) begin
				tok[0] = b;
				tl     = 3'd1;
			end else if ((b == CH_SP || b == CH_TAB) && nx != CH_LF && nx != CH_CR) begin
				tok[0] = b;
				tl     = 3'd1;
			end else if (b == CH_CR) begin
				tl = 3'd0;
			end else if (b == CH_LF) begin
				is_crlf = 1'b1;
			end
		end
		if (is_crlf) begin
			r.enc.chars[0] = CH_CR;
			r.enc.chars[1] = CH_LF;
			r.enc.len      = 3'd2;
			r.col          = '0;
		end else if (col >= sb_col) begin
			r.enc.chars = {tok[2], tok[1], tok[0], CH_LF, CH_CR, CH_EQ};
			r.enc.len   = 3'd3 + tl;
			r.col       = {{(COL_W-3){1'b0}}, tl};
		end else begin
			r.enc.chars[2:0] = tok;
			r.enc.len        = tl;
			r.col            = col + {{(COL_W-3){1'b0}}, tl};
		end
		return r;
	endfunction

endpackage

@@ design/qpe_front.sv @@
module qpe_front import qpe_pkg::*; #(
	parameter int MAX_LINE = MAX_LINE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             in_byte,
	input  logic                   end_of_message,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   q_full,
	output logic                   q_push,
	output job_t                   q_job
);

	localparam logic [COL_W-1:0] SB_COL = COL_W'(MAX_LINE - 1);

	logic [3:0][63:0]  mask_q;
	logic [7:0]        held_q;
	logic              held_valid_q;
	logic [COL_W-1:0]  col_q;

	enc_res_t          r0;
	enc_res_t          r1;
	logic [COL_W-1:0]  col_mid;
	logic              accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		r0      = qpe_encode(held_q, in_byte, mask_q[held_q[7:6]][held_q[5:0]], col_q, SB_COL);
		col_mid = held_valid_q ? r0.col : col_q;
		// The last byte of a message sees NUL as its successor.
		r1      = qpe_encode(in_byte, 8'd0, mask_q[in_byte[7:6]][in_byte[5:0]], col_mid,
			SB_COL);
		q_job.e[0] = r0.enc;
		q_job.e[1] = r1.enc;
		if (!held_valid_q)
			q_job.e[0].len = 3'd0;
		if (!end_of_message)
			q_job.e[1].len = 3'd0;
		q_push = accept && (q_job.e[0].len != 3'd0 || q_job.e[1].len != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q       <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			col_q        <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_FORCE_MASK_0: mask_q[0] <= cfg_data;
					REG_FORCE_MASK_1: mask_q[1] <= cfg_data;
					REG_FORCE_MASK_2: mask_q[2] <= cfg_data;
					REG_FORCE_MASK_3: mask_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (end_of_message) begin
					held_q       <= '0;
					held_valid_q <= 1'b0;
					col_q        <= '0;
				end else begin
					held_q       <= in_byte;
					held_valid_q <= 1'b1;
					col_q        <= col_mid;
				end
			end
		end
	end

endmodule

@@ design/qpe_fifo.sv @@
module qpe_fifo import qpe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t head_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t           mem [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head_job  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/qpe_back.sv @@
module qpe_back import qpe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end
);

	logic       sel_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_end_q;

	logic       sel;
	enc_t       cur;
	logic       last_in_enc;
	logic       done;
	logic       advance;

	always_comb begin
		// The front never queues a job without characters, so an empty first
		// part means the job starts in its second part.
		sel         = sel_q || (job.e[0].len == 3'd0);
		cur         = job.e[sel];
		last_in_enc = (idx_q == cur.len - 3'd1);
		done        = last_in_enc && (sel || job.e[1].len == 3'd0);
		advance     = job_valid && (!out_valid_q || !out_stall);
		pop         = advance && done;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign run_end   = run_end_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_char_q <= cur.chars[idx_q];
			run_end_q  <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (done) begin
					sel_q <= 1'b0;
					idx_q <= '0;
				end else if (last_in_enc) begin
					sel_q <= 1'b1;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/quoted_printable_encoder.sv @@
// Throughput: one character per cycle while the job queue holds a job and out_stall is low;
// each item causes zero to twelve characters (one for a typical byte), sent through the single output register.
// Items are accepted every cycle while the job queue between front and back has room.
// Reset clears the force masks, the held byte, the column count, the queue and the output valid flag.
module quoted_printable_encoder import qpe_pkg::*; #(
	parameter int MAX_LINE    = MAX_LINE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             in_byte,
	input  logic                   end_of_message,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_char,
	output logic                   run_end,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_not_empty;
	job_t push_job;
	job_t head_job;

	qpe_front #(.MAX_LINE(MAX_LINE)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_job          (push_job)
	);

	qpe_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (head_job)
	);

	qpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_not_empty),
		.job       (head_job),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.run_end   (run_end)
	);

endmodule
